### rtl/core/wfc_pkg.sv
// Shared types, constants and the CORDIC angle table for the waypoint
// follow controller. No dependencies.
package wfc_pkg;

    localparam int MAX_WP = 64;
    localparam int PTR_W  = $clog2(MAX_WP);
    localparam int CNT_W  = $clog2(MAX_WP + 1);
    localparam int POS_W  = 24;
    localparam int WP_W   = 2 * POS_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 23;

    localparam int SQRT_STEPS   = 25;
    localparam int CORDIC_STEPS = 20;

    localparam logic [1:0] KIND_STEP   = 2'd0;
    localparam logic [1:0] KIND_LOAD   = 2'd1;
    localparam logic [1:0] KIND_APPEND = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_LIN_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANG_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIN_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ANG_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_TOL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FINAL_TOL  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ALIGN_TOL  = 3'd6;

    localparam logic signed [17:0] PI_Q13     = 18'sd25736;
    localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;
    localparam logic signed [23:0] HALF_PI_Q20 = 24'sd1647099;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_DIFF, S_SQX, S_SQY, S_SQRT, S_CHK,
        S_CINIT, S_CORD, S_ERR, S_MUL, S_OUT
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP, DP_DIFF, DP_SQX, DP_SQY, DP_SQRT, DP_CINIT, DP_CSTEP, DP_ERR, DP_MUL
    } t_dp_op;

    typedef struct packed {
        t_dp_op           op;
        logic             cap;
        logic             we;
        logic [PTR_W-1:0] waddr;
        logic [PTR_W-1:0] raddr;
        logic [4:0]       step;
        logic             zero_lin;
        logic             zero_ang;
    } t_dp_cmd;

    typedef struct packed {
        logic               lt_arrive;
        logic               lt_final;
        logic               lt_align;
        logic [22:0]        lin;
        logic signed [15:0] ang;
    } t_dp_sts;

    function automatic logic signed [23:0] atan_q20(input logic [4:0] i);
        case (i)
            5'd0:  atan_q20 = 24'sd823550;
            5'd1:  atan_q20 = 24'sd486170;
            5'd2:  atan_q20 = 24'sd256879;
            5'd3:  atan_q20 = 24'sd130396;
            5'd4:  atan_q20 = 24'sd65451;
            5'd5:  atan_q20 = 24'sd32757;
            5'd6:  atan_q20 = 24'sd16383;
            5'd7:  atan_q20 = 24'sd8192;
            5'd8:  atan_q20 = 24'sd4096;
            5'd9:  atan_q20 = 24'sd2048;
            5'd10: atan_q20 = 24'sd1024;
            5'd11: atan_q20 = 24'sd512;
            5'd12: atan_q20 = 24'sd256;
            5'd13: atan_q20 = 24'sd128;
            5'd14: atan_q20 = 24'sd64;
            5'd15: atan_q20 = 24'sd32;
            5'd16: atan_q20 = 24'sd16;
            5'd17: atan_q20 = 24'sd8;
            5'd18: atan_q20 = 24'sd4;
            5'd19: atan_q20 = 24'sd2;
            default: atan_q20 = 24'sd0;
        endcase
    endfunction

endpackage

### rtl/core/wfc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module wfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/core/wfc_dp.sv
// Datapath: waypoint store, config registers, distance (square root),
// CORDIC bearing and command arithmetic. Depends on wfc_pkg, wfc_ram.
module wfc_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  wfc_pkg::t_dp_cmd                   i_cmd,
    input  logic signed [wfc_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [wfc_pkg::POS_W-1:0]   i_pos_y,
    input  logic signed [15:0]                 i_heading,
    input  logic                               i_cfg_we,
    input  logic [wfc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [wfc_pkg::CFG_DAT_W-1:0]      i_cfg_data,
    output wfc_pkg::t_dp_sts                   o_sts
);
    logic [15:0] r_lin_gain, r_ang_gain;
    logic [22:0] r_lin_limit, r_arrive_tol, r_final_tol;
    logic [14:0] r_ang_limit, r_align_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin_gain   <= 16'd4096;
            r_ang_gain   <= 16'd16384;
            r_lin_limit  <= 23'd131072;
            r_ang_limit  <= 15'd12868;
            r_arrive_tol <= 23'd1311;
            r_final_tol  <= 23'd197;
            r_align_tol  <= 15'd82;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                wfc_pkg::REG_LIN_GAIN:   r_lin_gain   <= i_cfg_data[15:0];
                wfc_pkg::REG_ANG_GAIN:   r_ang_gain   <= i_cfg_data[15:0];
                wfc_pkg::REG_LIN_LIMIT:  r_lin_limit  <= i_cfg_data;
                wfc_pkg::REG_ANG_LIMIT:  r_ang_limit  <= i_cfg_data[14:0];
                wfc_pkg::REG_ARRIVE_TOL: r_arrive_tol <= i_cfg_data;
                wfc_pkg::REG_FINAL_TOL:  r_final_tol  <= i_cfg_data;
                wfc_pkg::REG_ALIGN_TOL:  r_align_tol  <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    logic [wfc_pkg::WP_W-1:0] w_rdata;

    wfc_ram #(.WIDTH(wfc_pkg::WP_W), .DEPTH(wfc_pkg::MAX_WP)) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.we),
        .i_waddr (i_cmd.waddr),
        .i_wdata ({i_pos_x, i_pos_y}),
        .i_raddr (i_cmd.raddr),
        .o_rdata (w_rdata)
    );

    logic signed [23:0] r_px, r_py;
    logic signed [15:0] r_hd;
    logic signed [24:0] r_dx, r_dy;
    logic [48:0]        r_sq;
    logic [49:0]        r_rem, r_root, r_bit;
    logic signed [27:0] r_cx, r_cy;
    logic signed [23:0] r_cz;
    logic               r_zero;
    logic               r_neg;
    logic [15:0]        r_mag;
    logic [31:0]        r_angp;
    logic [40:0]        r_linp;

    logic signed [23:0] w_wx, w_wy;
    logic signed [49:0] w_sqx, w_sqy;
    logic [49:0]        w_trial;
    logic signed [27:0] w_xs, w_ys;
    logic signed [23:0] w_zr;
    logic signed [16:0] w_brg;
    logic signed [17:0] w_err, w_wrap;
    logic [24:0]        w_dist;
    logic [19:0]        w_ang_raw;
    logic [14:0]        w_ang_clip;
    logic [28:0]        w_lin_raw;

    always_comb begin
        w_wx    = w_rdata[47:24];
        w_wy    = w_rdata[23:0];
        w_sqx   = r_dx * r_dx;
        w_sqy   = r_dy * r_dy;
        w_trial = r_root + r_bit;
        w_xs    = r_cx >>> i_cmd.step;
        w_ys    = r_cy >>> i_cmd.step;
        w_zr    = r_cz + 24'sd64;
        w_brg   = r_zero ? 17'sd0 : w_zr[23:7];
        w_err   = {w_brg[16], w_brg} - {{2{r_hd[15]}}, r_hd};
        if (w_err > wfc_pkg::PI_Q13) begin
            w_wrap = w_err - wfc_pkg::TWO_PI_Q13;
        end else if (w_err <= -wfc_pkg::PI_Q13) begin
            w_wrap = w_err + wfc_pkg::TWO_PI_Q13;
        end else begin
            w_wrap = w_err;
        end
        w_dist     = r_root[24:0];
        w_ang_raw  = r_angp[31:12];
        w_ang_clip = (w_ang_raw > {5'd0, r_ang_limit}) ? r_ang_limit : w_ang_raw[14:0];
        w_lin_raw  = r_linp[40:12];

        o_sts.lt_arrive = w_dist < {2'd0, r_arrive_tol};
        o_sts.lt_final  = w_dist < {2'd0, r_final_tol};
        o_sts.lt_align  = r_mag < {1'b0, r_align_tol};
        if (i_cmd.zero_lin) begin
            o_sts.lin = '0;
        end else if (w_lin_raw > {6'd0, r_lin_limit}) begin
            o_sts.lin = r_lin_limit;
        end else begin
            o_sts.lin = w_lin_raw[22:0];
        end
        if (i_cmd.zero_ang) begin
            o_sts.ang = '0;
        end else if (r_neg) begin
            o_sts.ang = -$signed({1'b0, w_ang_clip});
        end else begin
            o_sts.ang = $signed({1'b0, w_ang_clip});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_px <= i_pos_x;
            r_py <= i_pos_y;
            r_hd <= i_heading;
        end
        case (i_cmd.op)
            wfc_pkg::DP_DIFF: begin
                r_dx <= {w_wx[23], w_wx} - {r_px[23], r_px};
                r_dy <= {w_wy[23], w_wy} - {r_py[23], r_py};
            end
            wfc_pkg::DP_SQX: begin
                r_sq <= w_sqx[48:0];
            end
            wfc_pkg::DP_SQY: begin
                r_rem  <= {1'b0, r_sq} + {1'b0, w_sqy[48:0]};
                r_root <= '0;
                r_bit  <= 50'd1 << 48;
            end
            wfc_pkg::DP_SQRT: begin
                if (r_rem >= w_trial) begin
                    r_rem  <= r_rem - w_trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            wfc_pkg::DP_CINIT: begin
                r_zero <= (r_dx == 25'sd0) && (r_dy == 25'sd0);
                if (r_dx < 0) begin
                    if (r_dy >= 0) begin
                        r_cx <= 28'(r_dy);
                        r_cy <= -28'(r_dx);
                        r_cz <= wfc_pkg::HALF_PI_Q20;
                    end else begin
                        r_cx <= -28'(r_dy);
                        r_cy <= 28'(r_dx);
                        r_cz <= -wfc_pkg::HALF_PI_Q20;
                    end
                end else begin
                    r_cx <= 28'(r_dx);
                    r_cy <= 28'(r_dy);
                    r_cz <= '0;
                end
            end
            wfc_pkg::DP_CSTEP: begin
                if (r_cy > 0) begin
                    r_cx <= r_cx + w_ys;
                    r_cy <= r_cy - w_xs;
                    r_cz <= r_cz + wfc_pkg::atan_q20(i_cmd.step);
                end else begin
                    r_cx <= r_cx - w_ys;
                    r_cy <= r_cy + w_xs;
                    r_cz <= r_cz - wfc_pkg::atan_q20(i_cmd.step);
                end
            end
            wfc_pkg::DP_ERR: begin
                r_neg <= w_wrap < 0;
                r_mag <= (w_wrap < 0) ? 16'(-w_wrap) : 16'(w_wrap);
            end
            wfc_pkg::DP_MUL: begin
                r_angp <= r_mag * r_ang_gain;
                r_linp <= w_dist * r_lin_gain;
            end
            default: ;
        endcase
    end
endmodule

### rtl/core/wfc_ctrl.sv
// Controller: sequencing state machine, waypoint bookkeeping and the
// output register. Depends on wfc_pkg.
module wfc_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_kind,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [22:0]                     o_linear_cmd,
    output logic signed [15:0]              o_angular_cmd,
    output logic                            o_goal_reached,
    output logic [5:0]                      o_target_index,
    output logic                            o_load_dropped,
    output wfc_pkg::t_dp_cmd                o_cmd,
    input  wfc_pkg::t_dp_sts                i_sts
);
    wfc_pkg::t_state              r_state, n_state;
    logic [wfc_pkg::CNT_W-1:0]    r_count, n_count;
    logic [wfc_pkg::PTR_W-1:0]    r_ptr, n_ptr;
    logic                         r_aligning, n_aligning;
    logic                         r_reached, n_reached;
    logic                         r_second, n_second;
    logic                         r_ctl, n_ctl;
    logic                         r_drop, n_drop;
    logic [4:0]                   r_step, n_step;
    logic                         r_out_valid, n_out_valid;
    logic                         w_accept, w_out_free, w_has_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wfc_pkg::S_IDLE;
            r_count     <= '0;
            r_ptr       <= '0;
            r_aligning  <= 1'b1;
            r_reached   <= 1'b0;
            r_second    <= 1'b0;
            r_ctl       <= 1'b0;
            r_drop      <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ptr       <= n_ptr;
            r_aligning  <= n_aligning;
            r_reached   <= n_reached;
            r_second    <= n_second;
            r_ctl       <= n_ctl;
            r_drop      <= n_drop;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload needs no reset
    always_ff @(posedge i_clk) begin
        if (r_state == wfc_pkg::S_OUT && w_out_free) begin
            o_linear_cmd   <= i_sts.lin;
            o_angular_cmd  <= i_sts.ang;
            o_goal_reached <= r_reached || (r_count == '0);
            o_target_index <= 6'(r_ptr);
            o_load_dropped <= r_drop;
        end
    end

    assign o_in_ready  = (r_state == wfc_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_has_room  = r_count < wfc_pkg::CNT_W'(wfc_pkg::MAX_WP);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_aligning  = r_aligning;
        n_reached   = r_reached;
        n_second    = r_second;
        n_ctl       = r_ctl;
        n_drop      = r_drop;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        o_cmd.op       = wfc_pkg::DP_NOP;
        o_cmd.cap      = w_accept;
        o_cmd.we       = 1'b0;
        o_cmd.waddr    = (i_kind == wfc_pkg::KIND_LOAD) ? '0 : r_count[wfc_pkg::PTR_W-1:0];
        o_cmd.raddr    = r_ptr;
        o_cmd.step     = r_step;
        o_cmd.zero_lin = !r_ctl || r_aligning || r_reached;
        o_cmd.zero_ang = !r_ctl || r_reached;

        case (r_state)
            wfc_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_drop   = 1'b0;
                    n_ctl    = 1'b0;
                    n_second = 1'b0;
                    n_state  = wfc_pkg::S_OUT;
                    case (i_kind)
                        wfc_pkg::KIND_STEP: begin
                            if (r_count != '0) begin
                                n_ctl   = 1'b1;
                                n_state = wfc_pkg::S_RD;
                            end
                        end
                        wfc_pkg::KIND_LOAD: begin
                            o_cmd.we   = 1'b1;
                            n_count    = wfc_pkg::CNT_W'(1);
                            n_ptr      = '0;
                            n_aligning = 1'b1;
                            n_reached  = 1'b0;
                        end
                        wfc_pkg::KIND_APPEND: begin
                            if (w_has_room) begin
                                o_cmd.we  = 1'b1;
                                n_count   = r_count + 1'b1;
                                n_reached = 1'b0;
                            end else begin
                                n_drop = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            wfc_pkg::S_RD:   n_state = wfc_pkg::S_DIFF;
            wfc_pkg::S_DIFF: begin
                o_cmd.op = wfc_pkg::DP_DIFF;
                n_state  = wfc_pkg::S_SQX;
            end
            wfc_pkg::S_SQX: begin
                o_cmd.op = wfc_pkg::DP_SQX;
                n_state  = wfc_pkg::S_SQY;
            end
            wfc_pkg::S_SQY: begin
                o_cmd.op = wfc_pkg::DP_SQY;
                n_step   = '0;
                n_state  = wfc_pkg::S_SQRT;
            end
            wfc_pkg::S_SQRT: begin
                o_cmd.op = wfc_pkg::DP_SQRT;
                n_step   = r_step + 1'b1;
                if (r_step == 5'(wfc_pkg::SQRT_STEPS - 1)) begin
                    n_state = wfc_pkg::S_CHK;
                end
            end
            wfc_pkg::S_CHK: begin
                n_state = wfc_pkg::S_CINIT;
                // the arrive test runs only on the first distance of a step, not after advancing
                if (!r_second && i_sts.lt_arrive) begin
                    if (({1'b0, r_ptr} + 1'b1) < r_count) begin
                        n_ptr      = r_ptr + 1'b1;
                        n_aligning = 1'b1;
                        n_second   = 1'b1;
                        n_state    = wfc_pkg::S_RD;
                    end else if (i_sts.lt_final) begin
                        n_reached = 1'b1;
                    end
                end
            end
            wfc_pkg::S_CINIT: begin
                o_cmd.op = wfc_pkg::DP_CINIT;
                n_step   = '0;
                n_state  = wfc_pkg::S_CORD;
            end
            wfc_pkg::S_CORD: begin
                o_cmd.op = wfc_pkg::DP_CSTEP;
                n_step   = r_step + 1'b1;
                if (r_step == 5'(wfc_pkg::CORDIC_STEPS - 1)) begin
                    n_state = wfc_pkg::S_ERR;
                end
            end
            wfc_pkg::S_ERR: begin
                o_cmd.op = wfc_pkg::DP_ERR;
                n_state  = wfc_pkg::S_MUL;
            end
            wfc_pkg::S_MUL: begin
                o_cmd.op = wfc_pkg::DP_MUL;
                n_state  = wfc_pkg::S_OUT;
            end
            wfc_pkg::S_OUT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = wfc_pkg::S_IDLE;
                    if (r_ctl && r_aligning && i_sts.lt_align) begin
                        n_aligning = 1'b0;
                    end
                end
            end
            default: n_state = wfc_pkg::S_IDLE;
        endcase
    end

    a_ptr_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> ({1'b0, r_ptr} < r_count))
        else $error("target pointer past end of list");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= wfc_pkg::CNT_W'(wfc_pkg::MAX_WP))
        else $error("waypoint count overflow");

    a_out_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wfc_pkg::S_OUT && w_out_free) |=> (r_state == wfc_pkg::S_IDLE && r_out_valid))
        else $error("result not posted on exit");

    a_no_step_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wfc_pkg::S_RD) |-> (r_count != '0))
        else $error("store read with empty list");
endmodule

### rtl/core/waypoint_follow_controller_top.sv
// Top level of the waypoint follow controller: joins controller and datapath.
// Depends on wfc_pkg, wfc_ctrl, wfc_dp (and wfc_ram below it).
//
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------------
//  in      | i_in_valid / o_in_ready| i_kind, i_pos_x, i_pos_y, i_heading
//  out     | o_out_valid/ i_out_ready| o_linear_cmd, o_angular_cmd, o_goal_reached,
//          |                        | o_target_index, o_load_dropped
//  cfg     | i_cfg_valid/ o_cfg_ready| i_cfg_index, i_cfg_data
//
// Loads, appends, unknown kinds and steps on an empty list go straight to the output.
// In a control step the square root runs 25 one-bit iterations per distance (a second
// distance when the target advances) and the CORDIC 20 rotations.
// One item is in work at a time; a result waiting in the output register does
// not block acceptance of the next item. Reset is synchronous, active low;
// configuration is always ready.
module waypoint_follow_controller_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_kind,
    input  logic signed [wfc_pkg::POS_W-1:0]    i_pos_x,
    input  logic signed [wfc_pkg::POS_W-1:0]    i_pos_y,
    input  logic signed [15:0]                  i_heading,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [22:0]                         o_linear_cmd,
    output logic signed [15:0]                  o_angular_cmd,
    output logic                                o_goal_reached,
    output logic [5:0]                          o_target_index,
    output logic                                o_load_dropped,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [wfc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [wfc_pkg::CFG_DAT_W-1:0]       i_cfg_data
);
    wfc_pkg::t_dp_cmd w_cmd;
    wfc_pkg::t_dp_sts w_sts;

    assign o_cfg_ready = 1'b1;

    wfc_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_linear_cmd   (o_linear_cmd),
        .o_angular_cmd  (o_angular_cmd),
        .o_goal_reached (o_goal_reached),
        .o_target_index (o_target_index),
        .o_load_dropped (o_load_dropped),
        .o_cmd          (w_cmd),
        .i_sts          (w_sts)
    );

    wfc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_heading   (i_heading),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_sts       (w_sts)
    );
endmodule
